FILE: hw/rtl/scsa_pkg.sv
// scsa_pkg: shared types, codes and helpers for the size-class scratch allocator.
// No dependencies; the allocator, front and back files refer to it by scoped names.
package scsa_pkg;

    localparam int unsigned LenBits   = 48;
    localparam int unsigned FileBits  = 4;
    localparam int unsigned MaxFiles  = 16;
    localparam int unsigned ClassBits = 6;
    localparam int unsigned CountBits = 5;
    // classes at or above this hold sizes beyond the granted_size field
    localparam logic [ClassBits-1:0] OversizeClass = 6'd48;

    typedef enum logic [1:0] {
        CMD_ALLOC   = 2'd0,
        CMD_RECYCLE = 2'd1,
        CMD_FAIL    = 2'd2,
        CMD_NOP     = 2'd3
    } t_cmd;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_LIMIT    = 3'd1,
        ST_NO_FILE  = 3'd2,
        ST_FULL     = 3'd3,
        ST_OVERFLOW = 3'd4
    } t_status;

    typedef enum logic [1:0] {
        CFG_LIMIT_EN   = 2'd0,
        CFG_BYTE_LIMIT = 2'd1,
        CFG_FILE_COUNT = 2'd2,
        CFG_START_FILE = 2'd3
    } t_cfg_idx;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_COUNT,
        BK_POP,
        BK_MOD,
        BK_SEARCH
    } t_bk_state;

    typedef struct packed {
        logic                 limit_en;
        logic [LenBits-1:0]   byte_limit;
        logic [CountBits-1:0] file_count;
        logic [FileBits-1:0]  start_file;
    } t_cfg;

    // classified item as it waits between front and back
    typedef struct packed {
        t_cmd                 cmd;
        logic [LenBits-1:0]   len;
        logic [FileBits-1:0]  file;
        logic [LenBits-1:0]   off;
        logic [ClassBits-1:0] cls;
    } t_item;

    // size class = ceil(log2(len)), with 0 and 1 both in class 0
    function automatic logic [ClassBits-1:0] size_class(input logic [LenBits-1:0] len);
        logic [LenBits-1:0]   lm1;
        logic [ClassBits-1:0] c;
        lm1 = len - LenBits'(1);
        c   = '0;
        if (len > LenBits'(1)) begin
            for (int i = 0; i < LenBits; i++) begin
                if (lm1[i]) c = ClassBits'(i + 1);
            end
        end
        return c;
    endfunction

endpackage

FILE: hw/rtl/scsa_req_if.sv
// scsa_req_if: request channel, valid/ready with the command payload.
// Depends on nothing.
interface scsa_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  cmd;
    logic [47:0] length_bytes;
    logic [3:0]  file_index;
    logic [47:0] range_offset;

    modport source (output valid, cmd, length_bytes, file_index, range_offset, input ready);
    modport sink   (input valid, cmd, length_bytes, file_index, range_offset, output ready);
endinterface

FILE: hw/rtl/scsa_rsp_if.sv
// scsa_rsp_if: result channel, valid/ready with status and granted range.
// Depends on nothing.
interface scsa_rsp_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic [3:0]  granted_file;
    logic [47:0] granted_offset;
    logic [47:0] granted_size;

    modport source (output valid, status, granted_file, granted_offset, granted_size,
                    input ready);
    modport sink   (input valid, status, granted_file, granted_offset, granted_size,
                    output ready);
endinterface

FILE: hw/rtl/size_class_scratch_allocator.sv
// Size-class scratch allocator: front classifier and queue, back executor.
// Fail/no-op and oversize items are answered from idle; recycles, byte limit
// and zero file count from the count state; stack pops from the pop state;
// bump allocations from search after mod steps and skipping failed files.
// Throughput: one item at a time in the back end; the queue holds two more.
// Reset (synchronous, active low) clears stack counts, fills, failed flags,
// the round-robin pointer, running total and configuration.
module size_class_scratch_allocator #(
    parameter int unsigned SIZE_CLASSES = 48,
    parameter int unsigned STACK_DEPTH  = 16,
    parameter int unsigned OFFSET_BITS  = 48
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [47:0] i_cfg_data,
    scsa_req_if.sink    i_req,
    scsa_rsp_if.source  o_rsp
);
    scsa_pkg::t_cfg  r_cfg;
    logic            q_valid, q_deq;
    scsa_pkg::t_item q_item;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.limit_en   <= 1'b0;
            r_cfg.byte_limit <= '0;
            r_cfg.file_count <= 5'd1;
            r_cfg.start_file <= '0;
        end else if (i_cfg_we) begin
            unique case (scsa_pkg::t_cfg_idx'(i_cfg_idx))
                scsa_pkg::CFG_LIMIT_EN:   r_cfg.limit_en   <= i_cfg_data[0];
                scsa_pkg::CFG_BYTE_LIMIT: r_cfg.byte_limit <= i_cfg_data;
                scsa_pkg::CFG_FILE_COUNT: r_cfg.file_count <= i_cfg_data[4:0];
                scsa_pkg::CFG_START_FILE: r_cfg.start_file <= i_cfg_data[3:0];
                default: ;
            endcase
        end
    end

    scsa_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (i_req),
        .o_q_valid (q_valid),
        .o_q_item  (q_item),
        .i_q_deq   (q_deq)
    );

    scsa_back #(
        .SIZE_CLASSES (SIZE_CLASSES),
        .STACK_DEPTH  (STACK_DEPTH),
        .OFFSET_BITS  (OFFSET_BITS)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_q_valid (q_valid),
        .i_q_item  (q_item),
        .o_q_deq   (q_deq),
        .o_rsp     (o_rsp)
    );
endmodule

FILE: hw/rtl/scsa_front.sv
// scsa_front: accepts requests, computes the size class, and holds them in a
// two-entry queue for the back end. Depends on scsa_pkg and scsa_req_if.
module scsa_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    scsa_req_if.sink          i_req,
    output logic              o_q_valid,
    output scsa_pkg::t_item   o_q_item,
    input  logic              i_q_deq
);
    scsa_pkg::t_item r_q [2];
    logic            r_wp, r_rp;
    logic [1:0]      r_cnt;
    logic            enq;
    scsa_pkg::t_item n_item;

    assign i_req.ready = (r_cnt != 2'd2);
    assign enq         = i_req.valid && i_req.ready;
    assign o_q_valid   = (r_cnt != 2'd0);
    assign o_q_item    = r_q[r_rp];

    // classify on the way in
    always_comb begin
        n_item.cmd  = scsa_pkg::t_cmd'(i_req.cmd);
        n_item.len  = i_req.length_bytes;
        n_item.file = i_req.file_index;
        n_item.off  = i_req.range_offset;
        n_item.cls  = scsa_pkg::size_class(i_req.length_bytes);
    end

    // queue payload
    always_ff @(posedge i_clk) begin
        if (enq) r_q[r_wp] <= n_item;
    end

    // queue pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (enq) r_wp <= ~r_wp;
            if (i_q_deq) r_rp <= ~r_rp;
            case ({enq, i_q_deq})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end
endmodule

FILE: hw/rtl/scsa_back.sv
// scsa_back: executes queued items: class stacks, byte limit, round-robin
// file choice and bump fill, with a registered result. Depends on scsa_pkg
// and scsa_rsp_if.
module scsa_back #(
    parameter int unsigned SIZE_CLASSES = 48,
    parameter int unsigned STACK_DEPTH  = 16,
    parameter int unsigned OFFSET_BITS  = 48
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  scsa_pkg::t_cfg    i_cfg,
    input  logic              i_q_valid,
    input  scsa_pkg::t_item   i_q_item,
    output logic              o_q_deq,
    scsa_rsp_if.source        o_rsp
);
    localparam int unsigned Entries = SIZE_CLASSES * STACK_DEPTH;
    localparam int unsigned CLW = (SIZE_CLASSES > 1) ? $clog2(SIZE_CLASSES) : 1;
    localparam int unsigned AW  = (Entries > 1) ? $clog2(Entries) : 1;
    localparam int unsigned CW  = $clog2(STACK_DEPTH + 1);
    localparam logic [63:0] OffMask = (64'd1 << OFFSET_BITS) - 64'd1;
    localparam int unsigned FB = scsa_pkg::FileBits;
    localparam int unsigned LB = scsa_pkg::LenBits;

    // memories
    logic [CW-1:0]  m_cnt  [SIZE_CLASSES];
    logic [FB-1:0]  m_file [Entries];
    logic [LB-1:0]  m_off  [Entries];

    scsa_pkg::t_bk_state r_state, n_state;
    scsa_pkg::t_item     r_item;
    logic [SIZE_CLASSES-1:0] r_cvalid;
    logic [CW-1:0]  r_cnt_rd;
    logic           r_cvld_rd;
    logic [FB-1:0]  r_stk_file;
    logic [LB-1:0]  r_stk_off;
    logic [FB-1:0]  r_rem, r_cur, r_next;
    logic [4:0]     r_tries;
    logic           r_load, r_opened;
    logic [48:0]    r_total;
    logic [scsa_pkg::MaxFiles-1:0] r_failed;
    logic [OFFSET_BITS-1:0] r_fill [scsa_pkg::MaxFiles];

    logic           r_ov;
    scsa_pkg::t_status r_st;
    logic [FB-1:0]  r_gf;
    logic [LB-1:0]  r_go, r_gs;

    // combinational controls
    logic           can_start, set_out;
    scsa_pkg::t_status out_st;
    logic [FB-1:0]  out_f;
    logic [LB-1:0]  out_o, out_s;
    logic [CLW-1:0] ra_cls, cls_idx;
    logic           cnt_we, stk_we, stk_re;
    logic [CW-1:0]  cnt_wd, cnt_eff;
    logic [AW-1:0]  stk_a;
    logic           has_stack;
    logic [LB-1:0]  size;
    logic [4:0]     n_files;
    logic [FB-1:0]  nxt;
    logic [63:0]    fill_sum;
    logic [49:0]    lim_sum, tot_sum;

    assign can_start = !r_ov || o_rsp.ready;
    assign o_q_deq   = (r_state == scsa_pkg::BK_IDLE) && i_q_valid && can_start;
    assign ra_cls    = (7'(i_q_item.cls) < 7'(SIZE_CLASSES)) ? i_q_item.cls[CLW-1:0] : '0;
    assign cls_idx   = (7'(r_item.cls) < 7'(SIZE_CLASSES)) ? r_item.cls[CLW-1:0] : '0;
    assign has_stack = (7'(r_item.cls) < 7'(SIZE_CLASSES));
    assign cnt_eff   = r_cvld_rd ? r_cnt_rd : '0;
    assign size      = LB'(1) << r_item.cls;
    assign n_files   = (i_cfg.file_count > 5'd16) ? 5'd16 : i_cfg.file_count;
    assign nxt       = (5'(r_cur) + 5'd1 == n_files) ? '0 : r_cur + FB'(1);
    assign fill_sum  = 64'(r_fill[r_cur]) + 64'(size);
    assign lim_sum   = 50'(r_total) + 50'(size);
    assign tot_sum   = 50'(r_total) + 50'(r_item.len);

    // next state and datapath controls
    always_comb begin
        n_state = r_state;
        set_out = 1'b0;
        out_st  = scsa_pkg::ST_OK;
        out_f   = '0;
        out_o   = '0;
        out_s   = '0;
        cnt_we  = 1'b0;
        cnt_wd  = '0;
        stk_we  = 1'b0;
        stk_re  = 1'b0;
        stk_a   = '0;
        unique case (r_state)
            scsa_pkg::BK_IDLE: begin
                if (o_q_deq) begin
                    unique case (i_q_item.cmd)
                        scsa_pkg::CMD_ALLOC: begin
                            if (i_q_item.cls >= scsa_pkg::OversizeClass) begin
                                set_out = 1'b1;
                                out_st  = scsa_pkg::ST_OVERFLOW;
                            end else begin
                                n_state = scsa_pkg::BK_COUNT;
                            end
                        end
                        scsa_pkg::CMD_RECYCLE: begin
                            if (i_q_item.cls >= scsa_pkg::OversizeClass ||
                                7'(i_q_item.cls) >= 7'(SIZE_CLASSES)) begin
                                set_out = 1'b1;
                                out_st  = scsa_pkg::ST_FULL;
                            end else begin
                                n_state = scsa_pkg::BK_COUNT;
                            end
                        end
                        default: begin
                            set_out = 1'b1;
                        end
                    endcase
                end
            end
            scsa_pkg::BK_COUNT: begin
                if (r_item.cmd == scsa_pkg::CMD_RECYCLE) begin
                    set_out = 1'b1;
                    n_state = scsa_pkg::BK_IDLE;
                    if (cnt_eff >= CW'(STACK_DEPTH)) begin
                        out_st = scsa_pkg::ST_FULL;
                    end else begin
                        cnt_we = 1'b1;
                        cnt_wd = cnt_eff + CW'(1);
                        stk_we = 1'b1;
                        stk_a  = AW'(32'(cls_idx) * 32'(STACK_DEPTH) + 32'(cnt_eff));
                    end
                end else if (has_stack && cnt_eff != '0) begin
                    cnt_we  = 1'b1;
                    cnt_wd  = cnt_eff - CW'(1);
                    stk_re  = 1'b1;
                    stk_a   = AW'(32'(cls_idx) * 32'(STACK_DEPTH) + 32'(cnt_wd));
                    n_state = scsa_pkg::BK_POP;
                end else if (i_cfg.limit_en && lim_sum > 50'(i_cfg.byte_limit)) begin
                    set_out = 1'b1;
                    out_st  = scsa_pkg::ST_LIMIT;
                    n_state = scsa_pkg::BK_IDLE;
                end else if (n_files == 5'd0) begin
                    set_out = 1'b1;
                    out_st  = scsa_pkg::ST_NO_FILE;
                    n_state = scsa_pkg::BK_IDLE;
                end else begin
                    n_state = scsa_pkg::BK_MOD;
                end
            end
            scsa_pkg::BK_POP: begin
                set_out = 1'b1;
                out_f   = r_stk_file;
                out_o   = r_stk_off;
                out_s   = size;
                n_state = scsa_pkg::BK_IDLE;
            end
            scsa_pkg::BK_MOD: begin
                if (5'(r_rem) < n_files) n_state = scsa_pkg::BK_SEARCH;
            end
            scsa_pkg::BK_SEARCH: begin
                if (r_tries == n_files) begin
                    set_out = 1'b1;
                    out_st  = scsa_pkg::ST_NO_FILE;
                    n_state = scsa_pkg::BK_IDLE;
                end else if (!r_failed[r_cur]) begin
                    set_out = 1'b1;
                    n_state = scsa_pkg::BK_IDLE;
                    if (fill_sum > OffMask) begin
                        out_st = scsa_pkg::ST_OVERFLOW;
                    end else begin
                        out_f = r_cur;
                        out_o = LB'(r_fill[r_cur]);
                        out_s = size;
                    end
                end
            end
            default: n_state = scsa_pkg::BK_IDLE;
        endcase
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= scsa_pkg::BK_IDLE;
        else          r_state <= n_state;
    end

    // class stack memories
    always_ff @(posedge i_clk) begin
        r_cnt_rd  <= m_cnt[ra_cls];
        r_cvld_rd <= r_cvalid[ra_cls];
        if (cnt_we) m_cnt[cls_idx] <= cnt_wd;
        if (stk_we) begin
            m_file[stk_a] <= r_item.file;
            m_off[stk_a]  <= r_item.off;
        end
        if (stk_re) begin
            r_stk_file <= m_file[stk_a];
            r_stk_off  <= m_off[stk_a];
        end
    end

    // item latch and search registers
    always_ff @(posedge i_clk) begin
        if (o_q_deq) r_item <= i_q_item;
        if (r_state == scsa_pkg::BK_COUNT) begin
            r_rem  <= r_opened ? r_next : i_cfg.start_file;
            r_load <= !r_opened;
        end
        if (r_state == scsa_pkg::BK_MOD) begin
            if (5'(r_rem) >= n_files) r_rem <= FB'(5'(r_rem) - n_files);
            r_cur   <= r_rem;
            r_tries <= 5'd0;
        end
        if (r_state == scsa_pkg::BK_SEARCH && r_failed[r_cur]) begin
            r_cur   <= nxt;
            r_tries <= r_tries + 5'd1;
        end
    end

    // allocator control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cvalid <= '0;
            r_opened <= 1'b0;
            r_next   <= '0;
            r_total  <= '0;
            r_failed <= '0;
            for (int i = 0; i < scsa_pkg::MaxFiles; i++) r_fill[i] <= '0;
        end else begin
            if (cnt_we) r_cvalid[cls_idx] <= 1'b1;
            if (o_q_deq && i_q_item.cmd == scsa_pkg::CMD_FAIL)
                r_failed[i_q_item.file] <= 1'b1;
            if (r_state == scsa_pkg::BK_COUNT && n_state == scsa_pkg::BK_MOD)
                r_opened <= 1'b1;
            if (r_state == scsa_pkg::BK_MOD && 5'(r_rem) < n_files && r_load)
                r_next <= r_rem;
            if (r_state == scsa_pkg::BK_SEARCH && r_tries != n_files &&
                !r_failed[r_cur] && fill_sum <= OffMask) begin
                r_fill[r_cur] <= OFFSET_BITS'(fill_sum);
                r_next        <= nxt;
                r_total       <= tot_sum[49] ? '1 : tot_sum[48:0];
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (set_out) begin
            r_ov <= 1'b1;
        end else if (o_rsp.ready) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (set_out) begin
            r_st <= out_st;
            r_gf <= out_f;
            r_go <= out_o;
            r_gs <= out_s;
        end
    end

    assign o_rsp.valid          = r_ov;
    assign o_rsp.status         = r_st;
    assign o_rsp.granted_file   = r_gf;
    assign o_rsp.granted_offset = r_go;
    assign o_rsp.granted_size   = r_gs;
endmodule
